// ===== rtl/fdlm_pkg.sv =====
// Shared definitions for the feedback delay / lowpass mixer: register codes,
// register widths and reset values, saturation limits, and the gain bundle type.
// No dependencies.
`default_nettype none

package fdlm_pkg;

	localparam int CHANNELS_DEF    = 2;
	localparam int DELAY_DEPTH_DEF = 131072;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int DLEN_W  = 18;
	localparam int COEFF_W = 17;
	localparam int FB_W    = 16;
	localparam int GAIN_W  = 17;

	typedef enum logic [2:0] {
		REG_DELAY_LEN    = 3'd0,
		REG_FILTER_COEFF = 3'd1,
		REG_FEEDBACK     = 3'd2,
		REG_WET          = 3'd3,
		REG_DRY          = 3'd4
	} reg_idx_t;

	localparam logic [DLEN_W-1:0]  DLEN_RST  = 18'd22050;
	localparam logic [COEFF_W-1:0] COEFF_RST = 17'd57363;
	localparam logic [FB_W-1:0]    FB_RST    = 16'd18678;
	localparam logic [GAIN_W-1:0]  WET_RST   = 17'd32768;
	localparam logic [GAIN_W-1:0]  DRY_RST   = 17'd52429;

	localparam logic [GAIN_W-1:0] UNITY_Q16    = 17'd65536;
	localparam logic [FB_W-1:0]   FEEDBACK_MAX = 16'd62259;

	// gains after range limiting, plus the clear request of a delay length write
	typedef struct packed {
		logic [COEFF_W-1:0] coeff;
		logic [FB_W-1:0]    fb;
		logic [GAIN_W-1:0]  wet;
		logic [GAIN_W-1:0]  dry;
		logic               clear;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/fdlm_cfg.sv =====
// Configuration register file on an APB-style port, with range limiting of
// the values it passes on. Depends on fdlm_pkg.
`default_nettype none

module fdlm_cfg import fdlm_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [ADDR_W-1:0]                  paddr,
	input  wire logic [DATA_W-1:0]                  pwdata,
	output logic      [DATA_W-1:0]                  prdata,
	output logic                                    pready,
	output cfg_t                                    cfg,
	output logic      [$clog2(DELAY_DEPTH+1)-1:0]   len
);

	localparam int LEN_W = $clog2(DELAY_DEPTH + 1);

	logic [DLEN_W-1:0]  dlen_q;
	logic [COEFF_W-1:0] coeff_q;
	logic [FB_W-1:0]    fb_q;
	logic [GAIN_W-1:0]  wet_q;
	logic [GAIN_W-1:0]  dry_q;
	logic               wr_en;
	reg_idx_t           idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlen_q  <= DLEN_RST;
			coeff_q <= COEFF_RST;
			fb_q    <= FB_RST;
			wet_q   <= WET_RST;
			dry_q   <= DRY_RST;
		end else if (wr_en) begin
			case (idx)
				REG_DELAY_LEN:    dlen_q  <= pwdata[DLEN_W-1:0];
				REG_FILTER_COEFF: coeff_q <= pwdata[COEFF_W-1:0];
				REG_FEEDBACK:     fb_q    <= pwdata[FB_W-1:0];
				REG_WET:          wet_q   <= pwdata[GAIN_W-1:0];
				REG_DRY:          dry_q   <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DELAY_LEN:    prdata = DATA_W'(dlen_q);
			REG_FILTER_COEFF: prdata = DATA_W'(coeff_q);
			REG_FEEDBACK:     prdata = DATA_W'(fb_q);
			REG_WET:          prdata = DATA_W'(wet_q);
			REG_DRY:          prdata = DATA_W'(dry_q);
			default:          prdata = '0;
		endcase
	end

	// a delay length write restarts every channel
	assign cfg.clear = wr_en && (idx == REG_DELAY_LEN);
	assign cfg.coeff = (coeff_q > UNITY_Q16) ? UNITY_Q16 : coeff_q;
	assign cfg.fb    = (fb_q > FEEDBACK_MAX) ? FEEDBACK_MAX : fb_q;
	assign cfg.wet   = (wet_q > UNITY_Q16) ? UNITY_Q16 : wet_q;
	assign cfg.dry   = (dry_q > UNITY_Q16) ? UNITY_Q16 : dry_q;

	always_comb begin
		if (dlen_q == '0) begin
			len = LEN_W'(1);
		end else if (32'(dlen_q) > 32'(DELAY_DEPTH)) begin
			len = LEN_W'(DELAY_DEPTH);
		end else begin
			len = LEN_W'(dlen_q);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fdlm_mem.sv =====
// Delay sample memory: one write port, one registered read port, with the
// write data bypassed to the read when both hit the same entry. No dependencies.
`default_nettype none

module fdlm_mem #(
	parameter int DEPTH = 262144,
	parameter int DW    = 24
) (
	input  wire logic                     clk,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DW-1:0]            rdata,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DW-1:0]            wdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/feedback_delay_lowpass_mix.sv =====
// Channel   | Handshake               | Payload
// input     | in_valid / in_stall     | channel, sample_in
// result    | out_valid / out_stall   | channel_out, sample_out
// config    | psel penable pwrite     | paddr, pwdata, prdata, pready
//
// An item's result is registered through the datapath stages and the output
// register; a new item is accepted only as the previous one leaves the last
// stage. The stages walk the delay memory: read, lowpass multiply, gain multiplies, write back.
// Reset and a delay length write clear pointers, filter state and per-channel
// fill flags at once; the memory is not swept, a slot reads as zero until the
// pointer has wrapped once. A stalled result holds the last stage and the input.
//
// Top level: control, channel state and datapath stages. Depends on fdlm_pkg,
// fdlm_cfg and fdlm_mem.
`default_nettype none

module feedback_delay_lowpass_mix import fdlm_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic        [ADDR_W-1:0]      paddr,
	input  wire logic        [DATA_W-1:0]      pwdata,
	output logic             [DATA_W-1:0]      prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          channel,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               channel_out,
	output logic signed      [SAMPLE_BITS-1:0] sample_out
);

	localparam int SB        = SAMPLE_BITS;
	localparam int PTR_W     = $clog2(DELAY_DEPTH);
	localparam int LEN_W     = $clog2(DELAY_DEPTH + 1);
	localparam int CI_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MEM_DEPTH = CHANNELS * (2 ** PTR_W);
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int LP_W      = SB + 19;
	localparam int FBP_W     = SB + 17;
	localparam int GP_W      = SB + 18;
	localparam int EW        = SB + 4;

	function automatic logic signed [SB-1:0] sat_s(input logic signed [EW-1:0] v);
		if (v[EW-1:SB-1] == '0 || v[EW-1:SB-1] == '1) begin
			return v[SB-1:0];
		end else if (v[EW-1]) begin
			return {1'b1, {(SB-1){1'b0}}};
		end else begin
			return {1'b0, {(SB-1){1'b1}}};
		end
	endfunction

	cfg_t             cfg;
	logic [LEN_W-1:0] len;

	fdlm_cfg #(
		.DELAY_DEPTH(DELAY_DEPTH)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg),
		.len    (len)
	);

	// per-channel state
	logic        [PTR_W-1:0]    ptr_q [CHANNELS];
	logic signed [SB-1:0]       lp_q  [CHANNELS];
	logic        [CHANNELS-1:0] wrap_q;

	// handshake
	logic accept;
	logic s4_go;
	logic out_valid_q;
	logic v_s1, v_s2, v_s3, v_s4;

	logic          ch_ok;
	logic [CI_W-1:0] idx_in;
	logic [AW-1:0] raddr;

	// stage payload
	logic                   ok_s1, ok_s2, ok_s3, ok_s4;
	logic                   ch_s1, ch_s2, ch_s3, ch_s4;
	logic [CI_W-1:0]        idx_s1, idx_s2;
	logic signed [SB-1:0]   x_s1, x_s2, x_s3, x_s4;
	logic [PTR_W-1:0]       ptr_s1, ptr_s2;
	logic [AW-1:0]          addr_s1, addr_s2, addr_s3, addr_s4;
	logic                   wrap_s1;
	logic signed [SB-1:0]   s_s2, s_s3;
	logic signed [LP_W-1:0] lp_prod_s2;
	logic signed [FBP_W-1:0] pf_s4;
	logic signed [GP_W-1:0] pd_s4, pw_s4;

	logic [SB-1:0]          rdata;
	logic signed [SB-1:0]   d_s1;
	logic signed [SB:0]     diff_s1;
	logic signed [LP_W-1:0] lp_prod;
	logic signed [EW-1:0]   lp_sum;
	logic signed [SB-1:0]   s_new;
	logic [LEN_W-1:0]       ptr_inc;
	logic signed [FBP_W-1:0] pf;
	logic signed [GP_W-1:0] pd, pw;
	logic signed [EW-1:0]   wsum, osum;
	logic signed [SB-1:0]   wdata, y;
	logic                   out_ch_q;
	logic signed [SB-1:0]   out_sample_q;

	assign s4_go    = v_s4 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 || v_s2 || v_s3 || (v_s4 && !s4_go);
	assign accept   = in_valid && !in_stall;

	assign ch_ok  = 32'(channel) < 32'(CHANNELS);
	assign idx_in = ch_ok ? CI_W'(channel) : '0;
	assign raddr  = AW'({idx_in, ptr_q[idx_in]});

	fdlm_mem #(
		.DEPTH(MEM_DEPTH),
		.DW   (SB)
	) u_mem (
		.clk  (clk),
		.re   (accept),
		.raddr(raddr),
		.rdata(rdata),
		.we   (s4_go && ok_s4),
		.waddr(addr_s4),
		.wdata(wdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 || (v_s4 && !s4_go);
		end
	end

	// stage 1: capture the item, memory read in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1   <= ch_ok;
			ch_s1   <= channel;
			idx_s1  <= idx_in;
			x_s1    <= sample_in;
			ptr_s1  <= ptr_q[idx_in];
			addr_s1 <= raddr;
			wrap_s1 <= wrap_q[idx_in];
		end
	end

	// a slot not yet revisited since the last clear reads as zero
	assign d_s1    = wrap_s1 ? $signed(rdata) : '0;
	assign diff_s1 = (SB+1)'(d_s1) - (SB+1)'(lp_q[idx_s1]);
	assign lp_prod = diff_s1 * $signed({1'b0, cfg.coeff});

	always_ff @(posedge clk) begin
		if (v_s1) begin
			ok_s2      <= ok_s1;
			ch_s2      <= ch_s1;
			idx_s2     <= idx_s1;
			x_s2       <= x_s1;
			ptr_s2     <= ptr_s1;
			addr_s2    <= addr_s1;
			s_s2       <= lp_q[idx_s1];
			lp_prod_s2 <= lp_prod;
		end
	end

	// stage 2: lowpass update, advance the pointer
	assign lp_sum  = EW'(s_s2) + EW'(lp_prod_s2 >>> 16);
	assign s_new   = sat_s(lp_sum);
	assign ptr_inc = LEN_W'(ptr_s2) + LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				ptr_q[i] <= '0;
				lp_q[i]  <= '0;
			end
			wrap_q <= '0;
		end else if (cfg.clear) begin
			for (int i = 0; i < CHANNELS; i++) begin
				ptr_q[i] <= '0;
				lp_q[i]  <= '0;
			end
			wrap_q <= '0;
		end else if (v_s2 && ok_s2) begin
			lp_q[idx_s2] <= s_new;
			if (ptr_inc >= len) begin
				ptr_q[idx_s2]  <= '0;
				wrap_q[idx_s2] <= 1'b1;
			end else begin
				ptr_q[idx_s2] <= ptr_inc[PTR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			ok_s3   <= ok_s2;
			ch_s3   <= ch_s2;
			x_s3    <= x_s2;
			addr_s3 <= addr_s2;
			s_s3    <= s_new;
		end
	end

	// stage 3: feedback, dry and wet products
	assign pf = s_s3 * $signed({1'b0, cfg.fb});
	assign pd = x_s3 * $signed({1'b0, cfg.dry});
	assign pw = s_s3 * $signed({1'b0, cfg.wet});

	always_ff @(posedge clk) begin
		if (v_s3) begin
			ok_s4   <= ok_s3;
			ch_s4   <= ch_s3;
			x_s4    <= x_s3;
			addr_s4 <= addr_s3;
			pf_s4   <= pf;
			pd_s4   <= pd;
			pw_s4   <= pw;
		end
	end

	// stage 4: write back and mix
	assign wsum  = EW'(x_s4) + EW'(pf_s4 >>> 16);
	assign wdata = sat_s(wsum);
	assign osum  = EW'(pd_s4 >>> 16) + EW'(pw_s4 >>> 16);
	assign y     = ok_s4 ? sat_s(osum) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s4_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_go) begin
			out_ch_q     <= ch_s4;
			out_sample_q <= y;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = out_ch_q;
	assign sample_out  = out_sample_q;

endmodule

`default_nettype wire

// ===== rtl/fdlm_checker.sv =====
// Port-level checks of the mixer's item timing and result hold, bound to
// the top level. No dependencies.
`default_nettype none

module fdlm_props #(
	parameter int SAMPLE_BITS = 24
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic                   channel_out,
	input wire logic [SAMPLE_BITS-1:0] sample_out
);

	// the sequencer holds off the input while an item is still in work
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall)
		else $error("input taken while an item is still in work");

	// a result appears in an empty output register only behind an item that was taken
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 5))
		else $error("result appeared without an item five cycles back");

	// while a result is held, the input stall rises only behind a taken item or as the hold begins
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && in_stall && !$past(in_stall)) |-> 1'b1 ##0
		$past(in_valid && !in_stall) || !$past(out_valid && out_stall))
		else $error("input stall raised without an item or a held result");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(sample_out) && $stable(channel_out))
		else $error("stalled result changed");

endmodule

bind feedback_delay_lowpass_mix fdlm_props #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_fdlm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.channel_out(channel_out),
	.sample_out (sample_out)
);

`default_nettype wire

// ===== dv/fdlm_checker.sv =====
// Checker for the feedback delay / lowpass mixer: snoops register writes and both
// item channels, predicts each result and compares it with what the block delivers.
// Depends on fdlm_pkg.
module fdlm_checker import fdlm_pkg::*; (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic                              pready,
	input  logic        [ADDR_W-1:0]          paddr,
	input  logic        [DATA_W-1:0]          pwdata,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              channel,
	input  logic signed [SAMPLE_BITS_DEF-1:0] sample_in,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              channel_out,
	input  logic signed [SAMPLE_BITS_DEF-1:0] sample_out,
	output int                                errors,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW    = SAMPLE_BITS_DEF;
	localparam int NCH   = CHANNELS_DEF;
	localparam int DEPTH = DELAY_DEPTH_DEF;
	localparam longint S_MAX = (longint'(1) << (SW - 1)) - 1;
	localparam longint S_MIN = -S_MAX - 1;

	typedef struct {
		logic              ch;
		logic signed [SW-1:0] smp;
	} echo_t;

	echo_t echo_q[$];

	logic signed [SW-1:0] tap_mem [NCH][DEPTH];
	int unsigned          tap_ptr [NCH];
	longint               lp_state [NCH];

	logic [DLEN_W-1:0]  len_reg;
	logic [COEFF_W-1:0] coeff_reg;
	logic [FB_W-1:0]    fb_reg;
	logic [GAIN_W-1:0]  wet_reg;
	logic [GAIN_W-1:0]  dry_reg;

	initial errors = 0;
	initial pending = 0;

	function automatic longint clip(input longint v);
		if (v > S_MAX)
			return S_MAX;
		if (v < S_MIN)
			return S_MIN;
		return v;
	endfunction

	function automatic longint limit_to(input longint v, input longint lim);
		return (v > lim) ? lim : v;
	endfunction

	task automatic report_error(input string msg);
		$display("%0t fdlm_checker: %s", $time, msg);
		errors++;
	endtask

	task automatic wipe_history();
		for (int c = 0; c < NCH; c++) begin
			for (int i = 0; i < DEPTH; i++)
				tap_mem[c][i] = '0;
			tap_ptr[c] = 0;
			lp_state[c] = 0;
		end
	endtask

	task automatic apply_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
		case (reg_idx_t'(idx))
			REG_DELAY_LEN: begin
				len_reg = data[DLEN_W-1:0];
				wipe_history();
			end
			REG_FILTER_COEFF: coeff_reg = data[COEFF_W-1:0];
			REG_FEEDBACK:     fb_reg = data[FB_W-1:0];
			REG_WET:          wet_reg = data[GAIN_W-1:0];
			REG_DRY:          dry_reg = data[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	// read the tap, smooth it, write back input plus feedback, mix the output
	task automatic echo_step(input logic ch, input logic signed [SW-1:0] x_in,
			output logic signed [SW-1:0] y);
		longint x, d, s, len, coeff, fb, wet, dry;
		int unsigned ptr;
		x = longint'(x_in);
		len = longint'(len_reg);
		if (len < 1)
			len = 1;
		if (len > DEPTH)
			len = DEPTH;
		ptr = tap_ptr[ch];
		if (ptr >= len)
			ptr = 0;
		coeff = limit_to(longint'(coeff_reg), longint'(UNITY_Q16));
		fb = limit_to(longint'(fb_reg), longint'(FEEDBACK_MAX));
		wet = limit_to(longint'(wet_reg), longint'(UNITY_Q16));
		dry = limit_to(longint'(dry_reg), longint'(UNITY_Q16));

		d = longint'(tap_mem[ch][ptr]);
		s = lp_state[ch];
		s = clip(s + ((coeff * (d - s)) >>> 16));
		lp_state[ch] = s;
		tap_mem[ch][ptr] = SW'(clip(x + ((s * fb) >>> 16)));
		tap_ptr[ch] = (ptr + 1 >= len) ? 0 : ptr + 1;
		y = SW'(clip(((x * dry) >>> 16) + ((s * wet) >>> 16)));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		echo_t want;
		echo_t nxt;
		logic signed [SW-1:0] y;
		if (!arst_n) begin
			len_reg = DLEN_RST;
			coeff_reg = COEFF_RST;
			fb_reg = FB_RST;
			wet_reg = WET_RST;
			dry_reg = DRY_RST;
			wipe_history();
			echo_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (echo_q.size() == 0) begin
					report_error($sformatf("result ch %0d sample %0d with no item waiting",
						channel_out, sample_out));
				end else begin
					want = echo_q[0];
					echo_q.delete(0);
					if (channel_out !== want.ch)
						report_error($sformatf("channel_out got %0d want %0d",
							channel_out, want.ch));
					if (sample_out !== want.smp)
						report_error($sformatf("sample_out got %0d want %0d (ch %0d)",
							sample_out, want.smp, want.ch));
				end
			end
			if (psel && penable && pwrite && pready)
				apply_write(paddr[ADDR_W-1:2], pwdata);
			if (in_valid && !in_stall) begin
				echo_step(channel, sample_in, y);
				nxt.ch = channel;
				nxt.smp = y;
				echo_q = {echo_q, nxt};
			end
			pending <= echo_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the feedback delay / lowpass mixer: clock, reset, register
// setup, item stimulus with idle and stall phases, watchdog and verdict.
// Depends on fdlm_pkg, feedback_delay_lowpass_mix and fdlm_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fdlm_pkg::*;

	localparam int SW = SAMPLE_BITS_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam logic signed [SW-1:0] S_HI = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_LO = {1'b1, {(SW-1){1'b0}}};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 channel = 1'b0;
	logic signed [SW-1:0] sample_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 channel_out;
	logic signed [SW-1:0] sample_out;

	int errors;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	feedback_delay_lowpass_mix dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .channel(channel), .sample_in(sample_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.channel_out(channel_out), .sample_out(sample_out)
	);

	fdlm_checker mix_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .channel(channel), .sample_in(sample_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.channel_out(channel_out), .sample_out(sample_out),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** feedback_delay_lowpass_mix: FAILED **");
			$finish;
		end
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// fill the bits above the register with noise
	task automatic write_field(input reg_idx_t idx, input int unsigned v, input int w);
		logic [DATA_W-1:0] mask;
		mask = (DATA_W'(1) << w) - 1;
		cfg_write(idx, ($urandom & ~mask) | (v & mask));
	endtask

	task automatic setup_phase(input bit with_len, input int unsigned dlen,
			input int unsigned coeff, input int unsigned fb,
			input int unsigned wet, input int unsigned dry);
		if (with_len)
			write_field(REG_DELAY_LEN, dlen, DLEN_W);
		write_field(REG_FILTER_COEFF, coeff, COEFF_W);
		write_field(REG_FEEDBACK, fb, FB_W);
		write_field(REG_WET, wet, GAIN_W);
		write_field(REG_DRY, dry, GAIN_W);
	endtask

	task automatic write_spares();
		for (int i = REG_DRY + 1; i < 8; i++)
			cfg_write(i[2:0], $urandom);
	endtask

	task automatic send_item(input logic ch, input logic signed [SW-1:0] s);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		sample_in <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic int unsigned pick_gain(input int unsigned unity, input int w);
		case ($urandom_range(5))
			0: return 0;
			1: return unity;
			2: return $urandom & ((1 << w) - 1);
			default: return $urandom_range(unity);
		endcase
	endfunction

	function automatic int unsigned pick_len();
		case ($urandom_range(9))
			0: return 0;
			1: return DELAY_DEPTH_DEF;
			2: return $urandom_range(DELAY_DEPTH_DEF + 1, (1 << DLEN_W) - 1);
			3: return $urandom_range(1, 1000);
			default: return $urandom_range(1, 48);
		endcase
	endfunction

	function automatic logic signed [SW-1:0] pick_sample();
		logic signed [SW-1:0] v;
		case ($urandom_range(7))
			0: return S_HI;
			1: return S_LO;
			2: begin
				v = SW'($urandom_range(511));
				return $urandom_range(1) ? -v : v;
			end
			default: return SW'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest delay, unity gains, maximum feedback, full-scale input drives both saturations
		setup_phase(1'b1, 1, 32'(UNITY_Q16), 32'(FEEDBACK_MAX), 32'(UNITY_Q16),
			32'(UNITY_Q16));
		send_item(1'b0, S_HI);
		send_item(1'b0, S_HI);
		send_item(1'b0, S_HI);
		send_item(1'b1, S_LO);
		send_item(1'b1, S_LO);
		send_item(1'b1, S_LO);
		send_item(1'b0, '0);
		send_item(1'b1, '1);
		send_item(1'b0, SW'(1));
		send_item(1'b1, S_HI);
		send_item(1'b0, S_LO);
		send_item(1'b1, '0);

		// zero length acts as one, over-range gains clamp, spare indexes ignored
		wait_drained();
		repeat (8) @(posedge clk);
		setup_phase(1'b1, 0, 32'h1FFFF, 32'hFFFF, 32'h1FFFF, 32'h1FFFF);
		write_spares();
		send_item(1'b0, S_HI);
		send_item(1'b0, S_HI);
		send_item(1'b1, S_LO);
		send_item(1'b1, S_LO);
		send_item(1'b0, '1);
		send_item(1'b1, SW'(1));

		// length above the memory depth, all gains zero
		wait_drained();
		repeat (8) @(posedge clk);
		setup_phase(1'b1, (1 << DLEN_W) - 1, 0, 0, 0, 0);
		send_item(1'b0, S_HI);
		send_item(1'b1, S_LO);

		for (int p = 0; p < 12; p++) begin
			wait_drained();
			repeat (8) @(posedge clk);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 56; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 56; end
				default: begin idle_pct = 17; stall_pct = 17; end
			endcase
			// a phase without a length write keeps the echo history
			setup_phase(1'($urandom_range(1)), pick_len(),
				pick_gain(32'(UNITY_Q16), COEFF_W),
				pick_gain(32'(FEEDBACK_MAX), FB_W), pick_gain(32'(UNITY_Q16), GAIN_W),
				pick_gain(32'(UNITY_Q16), GAIN_W));
			if ($urandom_range(3) == 0)
				write_spares();
			n = $urandom_range(50, 70);
			for (int k = 0; k < n; k++) begin
				if (k == 20 || $urandom_range(59) == 0)
					wait_drained();
				send_item(1'($urandom_range(1)), pick_sample());
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("** feedback_delay_lowpass_mix: PASSED **");
		else
			$display("** feedback_delay_lowpass_mix: FAILED **");
		$finish;
	end

endmodule
